[rtl/core/lazy_range_assign_range_query_tree_macros.svh]
// Assertion macros for the range tree top module
`ifndef LAZY_RANGE_ASSIGN_RANGE_QUERY_TREE_MACROS_SVH
`define LAZY_RANGE_ASSIGN_RANGE_QUERY_TREE_MACROS_SVH

// Implication checked on every edge outside reset
`define LRT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define LRT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/lrt_pkg.sv]
package lrt_pkg;

  localparam int unsigned Size      = 1024;
  localparam int unsigned LvlW      = $clog2(Size);
  localparam int unsigned Leaves    = 1 << LvlW;
  localparam int unsigned Nodes     = 2 * Leaves - 1;
  localparam int unsigned NodeW     = $clog2(Nodes);
  localparam int unsigned PosW      = LvlW + 1;
  localparam int unsigned StackD    = 2 * LvlW + 2;
  localparam int unsigned SpW       = $clog2(StackD + 1);

  localparam logic ActAssign = 1'b0;
  localparam logic ActQuery  = 1'b1;

  localparam logic [1:0] RegMode  = 2'd0;
  localparam logic [1:0] RegEmpty = 2'd1;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StPop,
    StVisit,
    StTagLeft,
    StTagRight,
    StFixRead,
    StFixWrite
  } state_e;

  // Stack frame: node, its span, and whether it is a post-order fix-up
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [PosW-1:0]  l;
    logic [PosW-1:0]  r;
    logic             fix;
  } frame_t;

  // One entry of the tree memory
  typedef struct packed {
    logic [31:0] val;
    logic [31:0] pend;
    logic        flag;
  } entry_t;

  // Signed-aware min/max combine
  function automatic logic [31:0] combine(input logic mode, input logic [31:0] a,
                                          input logic [31:0] b);
    logic a_less;
    a_less = $signed(a) < $signed(b);
    if (mode) combine = a_less ? b : a;
    else      combine = a_less ? a : b;
  endfunction

endpackage

[rtl/core/lrt_mem.sv]
// Tree node memory: one write port, one registered read port
module lrt_mem import lrt_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [NodeW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [NodeW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [Nodes];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lazy_range_assign_range_query_tree.sv]
// Channel   | Ports                                          | Direction
// ----------+------------------------------------------------+----------
// command   | start_i, busy_o, action_i, range_lo_i,         | in
//           | range_hi_i, fill_value_i                       |
// result    | done_o, range_result_o                         | out
// config    | psel, penable, pwrite, paddr, pwdata, prdata,  | in/out
//           | pready                                         |
//
// Each item walks the tree from a node stack: a visit costs a pop and a visit state,
// a tag pushed to the children a write to each child, an assign's fix-up of an inner
// node a pop that reads the left child, a read of the right child and a write. An empty
// query range is answered the cycle after it is accepted. The tree memory sets these costs.
// After reset and after each config write a clearing pass over every tree node runs;
// busy_o is high meanwhile. Results show for one cycle on done_o; the receiver cannot stall.
module lazy_range_assign_range_query_tree import lrt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [9:0]  range_lo_i,
  input  logic [10:0] range_hi_i,
  input  logic [31:0] fill_value_i,
  output logic        done_o,
  output logic [31:0] range_result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "lazy_range_assign_range_query_tree_macros.svh"

  state_e state_q, state_d;
  logic        mode_q;
  logic [31:0] empty_q;
  logic        clr_req_q;
  logic [NodeW-1:0] clr_q, clr_d;
  frame_t stack_q [StackD];
  logic [SpW-1:0] sp_q, sp_d;
  frame_t cur_q, cur_d;
  logic        act_q;
  logic [PosW-1:0] lo_q, hi_q;
  logic [31:0] x_q;
  logic [31:0] acc_q, acc_d;
  logic [31:0] left_q, left_d;
  logic [31:0] res_q, res_d;
  logic        done_q, done_d;
  logic        push_kids, push_fix;
  frame_t      kid_l, kid_r, fix_f, top_f;
  logic [NodeW-1:0] top_lc;
  logic        we;
  logic [NodeW-1:0] waddr, raddr;
  entry_t      wdata, rdata;
  logic        cfg_wr;
  logic [1:0]  reg_idx;
  logic        accept, nonempty;
  logic [PosW-1:0] hi_clip;
  logic [PosW-1:0] mid;
  logic [NodeW-1:0] lc, rc;
  logic [31:0] nval;
  logic        outside, covered;
  logic        ent_flag;
  logic [31:0] ent_val, ent_pend;

  lrt_mem u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = {1'b0, paddr[2]};
  always_comb begin
    case (reg_idx)
      RegMode:  prdata = {31'd0, mode_q};
      RegEmpty: prdata = empty_q;
      default:  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      empty_q   <= 32'h7FFF_FFFF;
      clr_req_q <= 1'b1;
    end else begin
      if (cfg_wr && reg_idx == RegMode) begin
        mode_q <= pwdata[0];
      end
      if (cfg_wr && reg_idx == RegEmpty) begin
        empty_q <= pwdata;
      end
      // a write during a clear runs another full clear afterwards
      if (cfg_wr) begin
        clr_req_q <= 1'b1;
      end else if (state_q == StIdle) begin
        clr_req_q <= 1'b0;
      end
    end
  end

  assign hi_clip  = (range_hi_i > PosW'(Size)) ? PosW'(Size) : range_hi_i;
  assign nonempty = {1'b0, range_lo_i} < hi_clip;
  assign accept   = start_i && !busy_o;

  // Node geometry for the current frame
  assign mid     = PosW'(({1'b0, cur_q.l} + {1'b0, cur_q.r}) >> 1);
  assign lc      = NodeW'({cur_q.node, 1'b0} + 12'd1);
  assign rc      = NodeW'({cur_q.node, 1'b0} + 12'd2);
  assign outside = (hi_q <= cur_q.l) || (cur_q.r <= lo_q);
  assign covered = (lo_q <= cur_q.l) && (cur_q.r <= hi_q);
  assign kid_l   = '{node: lc, l: cur_q.l, r: mid, fix: 1'b0};
  assign kid_r   = '{node: rc, l: mid, r: cur_q.r, fix: 1'b0};
  assign fix_f   = '{node: cur_q.node, l: cur_q.l, r: cur_q.r, fix: 1'b1};
  // Top of the stack and its left child
  assign top_f   = (sp_q == '0) ? '0 : stack_q[SpW'(sp_q - 1'b1)];
  assign top_lc  = NodeW'({top_f.node, 1'b0} + 12'd1);
  // A flagged node stands for a whole subtree holding its pending value
  assign ent_val  = rdata.flag ? rdata.pend : rdata.val;
  assign ent_flag = rdata.flag;
  assign ent_pend = rdata.pend;
  assign nval     = combine(mode_q, left_q, ent_val);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    sp_d      = sp_q;
    cur_d     = cur_q;
    acc_d     = acc_q;
    left_d    = left_q;
    res_d     = res_q;
    done_d    = 1'b0;
    push_kids = 1'b0;
    push_fix  = 1'b0;
    we        = 1'b0;
    waddr     = cur_q.node;
    wdata     = '0;
    raddr     = cur_q.node;
    case (state_q)
      StIdle: begin
        if (clr_req_q) begin
          state_d = StClear;
          clr_d   = '0;
        end else if (start_i) begin
          acc_d = empty_q;
          if (nonempty) begin
            cur_d   = '{node: '0, l: '0, r: PosW'(Leaves), fix: 1'b0};
            sp_d    = '0;
            raddr   = '0;
            state_d = StVisit;
          end else begin
            done_d = action_i == ActQuery;
            res_d  = empty_q;
          end
        end
      end
      StClear: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '{val: empty_q, pend: empty_q, flag: 1'b0};
        clr_d = NodeW'(clr_q + 1'b1);
        if (clr_q == NodeW'(Nodes - 1)) state_d = StIdle;
      end
      StPop: begin
        if (sp_q == '0) begin
          done_d  = act_q == ActQuery;
          res_d   = acc_q;
          state_d = StIdle;
        end else begin
          sp_d  = SpW'(sp_q - 1'b1);
          cur_d = top_f;
          if (top_f.fix) begin
            raddr   = top_lc;
            state_d = StFixRead;
          end else begin
            raddr   = top_f.node;
            state_d = StVisit;
          end
        end
      end
      StVisit: begin
        state_d = StPop;
        if (!outside) begin
          if (act_q == ActAssign) begin
            if (covered) begin
              we    = 1'b1;
              wdata = '{val: x_q, pend: x_q, flag: 1'b1};
            end else begin
              // descend, fix this node up after both children
              push_kids = 1'b1;
              push_fix  = 1'b1;
              sp_d      = SpW'(sp_q + 2'd3);
              if (ent_flag) begin
                left_d  = ent_pend;
                state_d = StTagLeft;
              end
            end
          end else if (covered || ent_flag) begin
            // full range takes the root alone, others fold in the identity
            acc_d = (covered && cur_q.node == '0) ? ent_val
                                                  : combine(mode_q, acc_q, ent_val);
          end else begin
            push_kids = 1'b1;
            sp_d      = SpW'(sp_q + 2'd2);
          end
        end
      end
      StTagLeft: begin
        // copy parent tag into both children, one per cycle
        we      = 1'b1;
        waddr   = lc;
        wdata   = '{val: left_q, pend: left_q, flag: 1'b1};
        state_d = StTagRight;
      end
      StTagRight: begin
        we      = 1'b1;
        waddr   = rc;
        wdata   = '{val: left_q, pend: left_q, flag: 1'b1};
        state_d = StPop;
      end
      StFixRead: begin
        // left child arrives, right child read issued
        left_d  = ent_val;
        raddr   = rc;
        state_d = StFixWrite;
      end
      StFixWrite: begin
        we      = 1'b1;
        wdata   = '{val: nval, pend: nval, flag: 1'b0};
        state_d = StPop;
      end
      default: state_d = StIdle;
    endcase
  end

  // Stack pushes: fix-up frame below the two children, left child on top
  always_ff @(posedge clk_i) begin
    if (push_kids) begin
      if (push_fix) begin
        stack_q[sp_q]               <= fix_f;
        stack_q[SpW'(sp_q + 1'b1)]  <= kid_r;
        stack_q[SpW'(sp_q + 2'd2)]  <= kid_l;
      end else begin
        stack_q[sp_q]               <= kid_r;
        stack_q[SpW'(sp_q + 1'b1)]  <= kid_l;
      end
    end
    if (accept) begin
      act_q <= action_i;
      lo_q  <= PosW'(range_lo_i);
      hi_q  <= hi_clip;
      x_q   <= fill_value_i;
    end
    acc_q  <= acc_d;
    left_q <= left_d;
    clr_q  <= clr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sp_q    <= '0;
      cur_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      cur_q   <= cur_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  assign busy_o         = (state_q != StIdle) || clr_req_q;
  assign done_o         = done_q;
  assign range_result_o = res_q;

  `LRT_ASSERT_IMP(a_sp_bound, clk_i, rst_ni, 1'b1, sp_q <= SpW'(StackD))
  `LRT_ASSERT_NXT(a_walk_start, clk_i, rst_ni, accept && nonempty, state_q == StVisit)
  `LRT_ASSERT_NXT(a_empty_answer, clk_i, rst_ni, accept && !nonempty && action_i == ActQuery, done_o)
  `LRT_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, state_q == StIdle)

endmodule

[tb/lazy_range_assign_range_query_tree_tb.sv]
module lazy_range_assign_range_query_tree_tb import lrt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Positions = Size;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned SettleCycles = 300;

  // Flat model of the range tree: the lazy tags never change what a query sees
  class range_scoreboard;
    logic [31:0] cell_vals[Positions];
    logic        max_mode;
    logic [31:0] ident;
    logic [31:0] pending_results[$];
    int unsigned errors;

    function void clear_all();
      foreach (cell_vals[i]) cell_vals[i] = ident;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == RegMode) max_mode = val[0];
      else if (idx == RegEmpty) ident = val;
      else return;
      clear_all();
    endfunction

    function logic [31:0] pick(logic [31:0] a, logic [31:0] b);
      logic a_less;
      a_less = $signed(a) < $signed(b);
      if (max_mode) return a_less ? b : a;
      return a_less ? a : b;
    endfunction

    // Note an accepted item; queries push their expected range value
    function void note_item(logic act, logic [9:0] lo, logic [10:0] hi, logic [31:0] val);
      int unsigned top;
      logic [31:0] acc;
      top = (hi > Positions) ? Positions : hi;
      if (act == ActAssign) begin
        for (int unsigned p = lo; p < top; p++) cell_vals[p] = val;
      end else begin
        // the whole tree answers from the root alone, other spans fold in the identity
        if (lo == 0 && top == Positions) acc = cell_vals[0];
        else acc = ident;
        for (int unsigned p = lo; p < top; p++) acc = pick(acc, cell_vals[p]);
        pending_results.push_back(acc);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %0d", $signed(got)));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          report($sformatf("range_result %0d, expected %0d", $signed(got), $signed(want)));
      end
    endtask
  endclass

  logic        clk_i, rst_ni;
  logic        start_i, busy_o, action_i, done_o;
  logic [9:0]  range_lo_i;
  logic [10:0] range_hi_i;
  logic [31:0] fill_value_i, range_result_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  range_scoreboard sb;
  int unsigned idle_cycles;

  lazy_range_assign_range_query_tree DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(range_result_o);
  end

  // Watchdog: cycles with no handshake of any kind
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Drive one item and hold it until accepted; start stays high for the next one
  task send_item(logic act, logic [9:0] lo, logic [10:0] hi, logic [31:0] val);
    action_i     <= act;
    range_lo_i   <= lo;
    range_hi_i   <= hi;
    fill_value_i <= val;
    start_i      <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_item(act, lo, hi, val);
  endtask

  task pause(int unsigned n);
    if (n == 0) return;
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Register write while idle; the block then clears its tree
  task write_reg(logic [1:0] idx, logic [31:0] val);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random range: mostly short spans, some wide, some empty, some with hi past the end
  task rand_range(output logic [9:0] lo, output logic [10:0] hi);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    lo = 10'($urandom);
    if (sel < 60) hi = 11'(lo + $urandom_range(0, 40));
    else if (sel < 80) hi = 11'($urandom_range(0, 2047));
    else if (sel < 90) begin
      lo = 10'($urandom_range(0, 64));
      hi = 11'($urandom_range(900, 2047));
    end else hi = 11'(lo);
  endtask

  task random_phase(int unsigned count);
    logic [9:0]  lo;
    logic [10:0] hi;
    logic [31:0] val;
    int unsigned burst, sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      for (int unsigned b = 0; b < burst && sent < count; b++) begin
        rand_range(lo, hi);
        case ($urandom_range(0, 9))
          0: val = 32'h8000_0000;
          1: val = 32'h7fff_ffff;
          2, 3: val = 32'($urandom_range(0, 15)) - 32'd8;
          default: val = $urandom;
        endcase
        send_item(($urandom_range(0, 1) != 0) ? ActQuery : ActAssign, lo, hi, val);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
    end
  endtask

  initial begin
    sb = new();
    sb.max_mode = 1'b0;
    sb.ident = 32'h7fff_ffff;
    sb.errors = 0;
    sb.clear_all();
    idle_cycles = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    action_i = ActAssign;
    range_lo_i = '0;
    range_hi_i = '0;
    fill_value_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty tree, extremes, clipping, empty ranges
    send_item(ActQuery, 10'd0, 11'd1024, 32'd0);
    send_item(ActQuery, 10'd5, 11'd5, 32'd0);
    send_item(ActAssign, 10'd0, 11'd1024, 32'h8000_0000);
    send_item(ActQuery, 10'd0, 11'd1024, 32'd0);
    send_item(ActAssign, 10'd1023, 11'd2047, 32'h7fff_ffff);
    send_item(ActQuery, 10'd1023, 11'd1024, 32'd0);
    send_item(ActQuery, 10'd1000, 11'd2047, 32'd0);
    send_item(ActAssign, 10'd10, 11'd3, 32'd55);
    send_item(ActQuery, 10'd10, 11'd3, 32'd0);
    send_item(ActAssign, 10'd3, 11'd10, 32'hffff_ffff);
    send_item(ActQuery, 10'd0, 11'd20, 32'd0);
    send_item(ActAssign, 10'd0, 11'd1, 32'd0);
    send_item(ActQuery, 10'd0, 11'd1, 32'd0);
    send_item(ActQuery, 10'd1023, 11'd1023, 32'd0);
    pause(5);
    write_reg(RegMode, 32'd1);
    send_item(ActQuery, 10'd0, 11'd1024, 32'd0);
    send_item(ActAssign, 10'd512, 11'd1024, 32'h8000_0000);
    send_item(ActAssign, 10'd511, 11'd513, 32'd7);
    send_item(ActQuery, 10'd0, 11'd1024, 32'd0);
    send_item(ActQuery, 10'd600, 11'd1500, 32'd0);
    write_reg(RegEmpty, 32'h8000_0000);
    send_item(ActQuery, 10'd0, 11'd1024, 32'd0);
    send_item(ActAssign, 10'd100, 11'd200, 32'h7fff_ffff);
    send_item(ActQuery, 10'd0, 11'd1024, 32'd0);

    // Random phases across settings, extremes among them
    random_phase(380);
    write_reg(RegMode, 32'hffff_fffe);
    random_phase(380);
    write_reg(RegEmpty, 32'd0);
    random_phase(380);
    write_reg(RegMode, 32'd1);
    write_reg(RegEmpty, $urandom);
    random_phase(380);

    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[lazy_range_assign_range_query_tree.f]
+incdir+rtl/core
rtl/core/lrt_pkg.sv
rtl/core/lrt_mem.sv
rtl/core/lazy_range_assign_range_query_tree.sv
tb/lazy_range_assign_range_query_tree_tb.sv
